### rtl/xadd_pkg.sv
package xadd_pkg;

    localparam int DEF_MAX_ENTRIES = 1024;

    localparam int BYTE_W   = 8;
    localparam int SIZE_W   = 32;
    localparam int INDEX_W  = 10;
    localparam int KIND_W   = 4;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 8;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 56;

    localparam logic [CFG_AW-1:0] REG_XOR_KEY      = 2'd0;
    localparam logic [CFG_AW-1:0] REG_HEADER_BYTES = 2'd1;
    localparam logic [CFG_AW-1:0] REG_GAP_BYTES    = 2'd2;

    localparam logic [CFG_DW-1:0] XOR_KEY_RST      = 8'hF7;
    localparam logic [CFG_DW-1:0] HEADER_BYTES_RST = 8'd8;
    localparam logic [CFG_DW-1:0] GAP_BYTES_RST    = 8'd8;

    localparam logic [7:0] SIZE_FIELD_BYTES = 8'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEEK_RD,
        ST_SEEK_CHK
    } ctrl_state_t;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_GAP,
        PH_NAMELEN,
        PH_NAME,
        PH_SIZE,
        PH_PAYLOAD,
        PH_EXCESS
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER    = 4'd0,
        KIND_GAP       = 4'd1,
        KIND_FLAG_MORE = 4'd2,
        KIND_FLAG_END  = 4'd3,
        KIND_NAME_LEN  = 4'd4,
        KIND_NAME_CHAR = 4'd5,
        KIND_SIZE_BYTE = 4'd6,
        KIND_PAYLOAD   = 4'd7,
        KIND_EXCESS    = 4'd8
    } kind_t;

    typedef struct packed {
        logic take;
        logic seek_rd;
        logic seek_chk;
    } cmd_t;

    typedef struct packed {
        logic seek_req;
        logic seek_hit;
        logic seek_zero;
        logic out_busy;
    } sts_t;

endpackage

### rtl/xadd_ram.sv
module xadd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/xadd_ctrl.sv
module xadd_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  xadd_pkg::sts_t sts,
    output xadd_pkg::cmd_t cmd
);

    xadd_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= xadd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.take     = 1'b0;
        cmd.seek_rd  = 1'b0;
        cmd.seek_chk = 1'b0;
        unique case (state_reg)
            xadd_pkg::ST_IDLE: begin
                s_tready = !sts.out_busy;
                cmd.take = s_tvalid && !sts.out_busy;
                if (cmd.take && sts.seek_req) begin
                    state_next = xadd_pkg::ST_SEEK_RD;
                end
            end
            xadd_pkg::ST_SEEK_RD: begin
                cmd.seek_rd = 1'b1;
                state_next  = sts.seek_hit ? xadd_pkg::ST_SEEK_CHK : xadd_pkg::ST_IDLE;
            end
            xadd_pkg::ST_SEEK_CHK: begin
                cmd.seek_chk = 1'b1;
                state_next   = sts.seek_zero ? xadd_pkg::ST_SEEK_RD : xadd_pkg::ST_IDLE;
            end
            default: begin
                state_next = xadd_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_seek_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.take && sts.seek_req) |=> state_reg == xadd_pkg::ST_SEEK_RD)
        else $error("table scan did not start after a request that needs it");

    a_chk_after_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == xadd_pkg::ST_SEEK_CHK |-> $past(state_reg) == xadd_pkg::ST_SEEK_RD)
        else $error("size check without a preceding table read");
`endif

endmodule

### rtl/xadd_dp.sv
module xadd_dp #(
    parameter int MAX_ENTRIES = xadd_pkg::DEF_MAX_ENTRIES
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [xadd_pkg::CFG_AW-1:0]        cfg_addr,
    input  logic [xadd_pkg::CFG_DW-1:0]        cfg_wr_data,
    input  logic [xadd_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [xadd_pkg::M_DATA_W-1:0]      m_tdata,
    output logic [xadd_pkg::KIND_W-1:0]        m_tuser,
    output logic                               m_tlast,
    input  xadd_pkg::cmd_t                     cmd,
    output xadd_pkg::sts_t                     sts
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int EW = $clog2(MAX_ENTRIES + 1);
    localparam int XW = (EW > xadd_pkg::INDEX_W) ? EW : xadd_pkg::INDEX_W;
    localparam int SW = xadd_pkg::SIZE_W;
    localparam int BW = xadd_pkg::BYTE_W;

    logic [BW-1:0] key_reg, key_next;
    logic [BW-1:0] hdr_reg, hdr_next;
    logic [BW-1:0] gap_reg, gap_next;

    xadd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]    fcnt_reg, fcnt_next;
    logic [EW-1:0] ecnt_reg, ecnt_next;
    logic [SW-1:0] shift_reg, shift_next;
    logic [SW-1:0] total_reg, total_next;
    logic [SW-1:0] pcount_reg, pcount_next;
    logic [EW-1:0] pentry_reg, pentry_next;
    logic [SW-1:0] pleft_reg, pleft_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic          drop_reg, drop_next;
    logic          anydrop_reg, anydrop_next;

    logic                       out_valid_reg, out_valid_next;
    logic [BW-1:0]              out_byte_reg, out_byte_next;
    xadd_pkg::kind_t            out_kind_reg, out_kind_next;
    logic [xadd_pkg::INDEX_W-1:0] out_idx_reg, out_idx_next;
    logic                       out_done_reg, out_done_next;
    logic [SW-1:0]              out_size_reg, out_size_next;
    logic                       out_serr_reg, out_serr_next;
    logic                       out_tfull_reg, out_tfull_next;

    logic [BW-1:0] plain;
    logic [EW-1:0] cur_idx;
    logic [EW-1:0] idx;
    logic [XW-1:0] idx_x;
    logic          as_flag;
    logic          seek;
    logic          ram_we;
    logic [SW-1:0] ram_rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg       <= xadd_pkg::XOR_KEY_RST;
            hdr_reg       <= xadd_pkg::HEADER_BYTES_RST;
            gap_reg       <= xadd_pkg::GAP_BYTES_RST;
            phase_reg     <= xadd_pkg::PH_HEADER;
            fcnt_reg      <= '0;
            ecnt_reg      <= '0;
            shift_reg     <= '0;
            total_reg     <= '0;
            pcount_reg    <= '0;
            pentry_reg    <= '0;
            pleft_reg     <= '0;
            cur_reg       <= '0;
            drop_reg      <= 1'b0;
            anydrop_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            key_reg       <= key_next;
            hdr_reg       <= hdr_next;
            gap_reg       <= gap_next;
            phase_reg     <= phase_next;
            fcnt_reg      <= fcnt_next;
            ecnt_reg      <= ecnt_next;
            shift_reg     <= shift_next;
            total_reg     <= total_next;
            pcount_reg    <= pcount_next;
            pentry_reg    <= pentry_next;
            pleft_reg     <= pleft_next;
            cur_reg       <= cur_next;
            drop_reg      <= drop_next;
            anydrop_reg   <= anydrop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg  <= out_byte_next;
        out_kind_reg  <= out_kind_next;
        out_idx_reg   <= out_idx_next;
        out_done_reg  <= out_done_next;
        out_size_reg  <= out_size_next;
        out_serr_reg  <= out_serr_next;
        out_tfull_reg <= out_tfull_next;
    end

    always_comb begin
        key_next = key_reg;
        hdr_next = hdr_reg;
        gap_next = gap_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                xadd_pkg::REG_XOR_KEY:      key_next = cfg_wr_data;
                xadd_pkg::REG_HEADER_BYTES: hdr_next = cfg_wr_data;
                xadd_pkg::REG_GAP_BYTES:    gap_next = cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign plain   = s_tdata[BW-1:0] ^ key_reg;
    assign cur_idx = drop_reg ? '0 : EW'(cur_reg);

    always_comb begin
        phase_next   = phase_reg;
        fcnt_next    = fcnt_reg;
        ecnt_next    = ecnt_reg;
        shift_next   = shift_reg;
        total_next   = total_reg;
        pcount_next  = pcount_reg;
        pentry_next  = pentry_reg;
        pleft_next   = pleft_reg;
        cur_next     = cur_reg;
        drop_next    = drop_reg;
        anydrop_next = anydrop_reg;

        out_valid_next = (m_tready) ? 1'b0 : out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_kind_next  = out_kind_reg;
        out_idx_next   = out_idx_reg;
        out_done_next  = out_done_reg;
        out_size_next  = out_size_reg;
        out_serr_next  = out_serr_reg;
        out_tfull_next = out_tfull_reg;

        idx     = '0;
        idx_x   = '0;
        as_flag = 1'b0;
        seek    = 1'b0;
        ram_we  = 1'b0;

        sts.seek_hit  = pentry_reg < ecnt_reg;
        sts.seek_zero = ram_rd_data == '0;
        sts.out_busy  = out_valid_reg && !m_tready;

        if (cmd.take) begin
            out_valid_next = 1'b1;
            out_byte_next  = plain;
            out_kind_next  = xadd_pkg::KIND_EXCESS;
            out_done_next  = 1'b0;
            out_size_next  = '0;
            out_serr_next  = 1'b0;
            out_tfull_next = 1'b0;

            unique case (phase_reg)
                xadd_pkg::PH_HEADER: begin
                    if (fcnt_reg < hdr_reg) begin
                        out_kind_next = xadd_pkg::KIND_HEADER;
                        fcnt_next     = fcnt_reg + 8'd1;
                    end else begin
                        as_flag = 1'b1;
                    end
                end
                xadd_pkg::PH_GAP: begin
                    if (fcnt_reg < gap_reg) begin
                        out_kind_next = xadd_pkg::KIND_GAP;
                        idx           = cur_idx;
                        fcnt_next     = fcnt_reg + 8'd1;
                    end else begin
                        as_flag = 1'b1;
                    end
                end
                xadd_pkg::PH_NAMELEN: begin
                    out_kind_next = xadd_pkg::KIND_NAME_LEN;
                    idx           = cur_idx;
                    fcnt_next     = plain;
                    shift_next    = '0;
                    phase_next    = (plain == '0) ? xadd_pkg::PH_SIZE : xadd_pkg::PH_NAME;
                end
                xadd_pkg::PH_NAME: begin
                    out_kind_next = xadd_pkg::KIND_NAME_CHAR;
                    idx           = cur_idx;
                    fcnt_next     = fcnt_reg - 8'd1;
                    if (fcnt_next == '0) begin
                        out_done_next = 1'b1;
                        phase_next    = xadd_pkg::PH_SIZE;
                    end
                end
                xadd_pkg::PH_SIZE: begin
                    out_kind_next = xadd_pkg::KIND_SIZE_BYTE;
                    idx           = cur_idx;
                    shift_next    = {plain, shift_reg[SW-1:BW]};
                    fcnt_next     = fcnt_reg + 8'd1;
                    if (fcnt_next >= xadd_pkg::SIZE_FIELD_BYTES) begin
                        out_done_next = 1'b1;
                        out_size_next = shift_next;
                        total_next    = total_reg + shift_next;
                        ram_we        = !drop_reg;
                        fcnt_next     = '0;
                        phase_next    = xadd_pkg::PH_GAP;
                    end
                end
                xadd_pkg::PH_PAYLOAD: begin
                    out_kind_next = xadd_pkg::KIND_PAYLOAD;
                    idx           = pentry_reg;
                    pcount_next   = pcount_reg + 32'd1;
                    pleft_next    = pleft_reg - 32'd1;
                    if (pleft_next == '0) begin
                        out_done_next = 1'b1;
                        pentry_next   = pentry_reg + EW'(1);
                        seek          = 1'b1;
                    end
                end
                default: begin
                    out_kind_next = xadd_pkg::KIND_EXCESS;
                    pcount_next   = pcount_reg + 32'd1;
                end
            endcase

            if (as_flag) begin
                fcnt_next = '0;
                if (plain == '0) begin
                    out_kind_next = xadd_pkg::KIND_FLAG_MORE;
                    if (ecnt_reg < EW'(MAX_ENTRIES)) begin
                        cur_next  = ecnt_reg[AW-1:0];
                        drop_next = 1'b0;
                        ecnt_next = ecnt_reg + EW'(1);
                        idx       = ecnt_reg;
                    end else begin
                        drop_next      = 1'b1;
                        anydrop_next   = 1'b1;
                        out_tfull_next = 1'b1;
                        idx            = '0;
                    end
                    phase_next = xadd_pkg::PH_NAMELEN;
                end else begin
                    out_kind_next = xadd_pkg::KIND_FLAG_END;
                    pentry_next   = '0;
                    seek          = 1'b1;
                end
            end

            // The table scan always ends in the payload or excess phase.
            if (seek) begin
                phase_next = xadd_pkg::PH_EXCESS;
            end

            if (s_tlast) begin
                if (phase_next == xadd_pkg::PH_PAYLOAD || phase_next == xadd_pkg::PH_EXCESS) begin
                    out_serr_next = total_next != pcount_next;
                end else begin
                    out_serr_next = 1'b1;
                end
                if (anydrop_next) begin
                    out_tfull_next = 1'b1;
                end
                seek         = 1'b0;
                phase_next   = xadd_pkg::PH_HEADER;
                fcnt_next    = '0;
                ecnt_next    = '0;
                shift_next   = '0;
                total_next   = '0;
                pcount_next  = '0;
                pentry_next  = '0;
                pleft_next   = '0;
                cur_next     = '0;
                drop_next    = 1'b0;
                anydrop_next = 1'b0;
            end

            idx_x        = XW'(idx);
            out_idx_next = idx_x[xadd_pkg::INDEX_W-1:0];
        end

        if (cmd.seek_rd && !sts.seek_hit) begin
            phase_next = xadd_pkg::PH_EXCESS;
        end

        if (cmd.seek_chk) begin
            if (sts.seek_zero) begin
                pentry_next = pentry_reg + EW'(1);
            end else begin
                pleft_next = ram_rd_data;
                phase_next = xadd_pkg::PH_PAYLOAD;
            end
        end

        sts.seek_req = seek;
    end

    xadd_ram #(
        .WIDTH(SW),
        .DEPTH(MAX_ENTRIES)
    ) u_size_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (cur_reg),
        .wr_data (shift_next),
        .rd_en   (cmd.seek_rd && sts.seek_hit),
        .rd_addr (pentry_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_done_reg;
    assign m_tdata  = {4'b0000, out_tfull_reg, out_serr_reg, out_size_reg, out_idx_reg,
                       out_byte_reg};

`ifndef SYNTHESIS
    a_payload_live: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == xadd_pkg::PH_PAYLOAD |-> (pleft_reg != '0 && pentry_reg < ecnt_reg))
        else $error("payload phase without a stored entry left to fill");

    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.seek_rd || cmd.seek_chk) |-> !ram_we)
        else $error("size table written during a table scan");
`endif

endmodule

### rtl/xor_archive_directory_deframer.sv
// Decodes an XOR-keyed archive one byte per request and tags every byte with its role in the
// directory (header, gap, flag, name length, name, size), payload or excess, plus the entry it
// belongs to. The three configuration registers (key, header length, gap length) are written
// through the cfg port; write them only while the block is idle, which the block does not
// enforce. Unless the output stalls or a scan runs, the next byte is accepted in the following
// cycle, with one output register between the two sides. After an end-of-directory flag or the
// last payload byte of an entry, the block scans the stored size table for the next entry with a
// nonzero size through its single read port: the next byte waits while each entry examined is
// read, then checked, and for a final read when the scan runs past the last entry. The last byte
// of an archive (s_tlast) reports the size check and a full table, and the block starts over.
module xor_archive_directory_deframer #(
    parameter int MAX_ENTRIES = xadd_pkg::DEF_MAX_ENTRIES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [xadd_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [xadd_pkg::CFG_DW-1:0]   cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // raw_byte[7:0]
    input  logic [xadd_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // plain_byte[7:0], entry_index[17:8], entry_size[49:18], size_error[50], table_full[51]
    output logic [xadd_pkg::M_DATA_W-1:0] m_tdata,
    // kind[3:0]
    output logic [xadd_pkg::KIND_W-1:0]   m_tuser,
    output logic                          m_tlast
);

    xadd_pkg::cmd_t cmd;
    xadd_pkg::sts_t sts;

    xadd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    xadd_dp #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule
